// ===== sv/lps_pkg.sv =====
`default_nettype none
package lps_pkg;

    localparam int LED_OUT_W  = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_SHADOW = 2'd0;
    localparam mode_t MODE_JOHNSON = 2'd1;
    localparam mode_t MODE_LIGHT = 2'd2;
    localparam mode_t MODE_UNUSED = 2'd3;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_STEP_TICKS = 1'd0;
    localparam cfg_addr_t REG_LONG_PRESS = 1'd1;

    localparam logic [TICK_W-1:0] STEP_TICKS_RST = 16'd200;
    localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [TICK_W-1:0] PRESS_MAX = 16'hFFFF;

    typedef struct packed {
        logic                 frozen;
        mode_t                mode;
        logic [LED_OUT_W-1:0] leds;
    } lps_result_t;

    localparam int RESULT_W = $bits(lps_result_t);

endpackage
`default_nettype wire

// ===== sv/lps_pattern.sv =====
`default_nettype none
module lps_pattern #(
    parameter int LED_COUNT = 8,
    parameter int STEP_W    = 4
) (
    input  wire lps_pkg::mode_t           mode,
    input  wire logic [STEP_W-1:0]        step,
    output logic [lps_pkg::LED_OUT_W-1:0] leds
);
    import lps_pkg::*;

    localparam logic [STEP_W:0] N_STEPS = (STEP_W+1)'(LED_COUNT);

    logic [STEP_W:0] step_w;
    logic [STEP_W:0] fill_s;
    logic [STEP_W:0] empty_s;

    always_comb begin
        step_w  = {1'b0, step};
        fill_s  = step_w - N_STEPS;
        empty_s = (fill_s >= N_STEPS) ? (N_STEPS - 1'b1) : fill_s;
        for (int i = 0; i < LED_OUT_W; i++) begin
            if (i >= LED_COUNT) begin
                leds[i] = 1'b0;
            end else begin
                case (mode)
                    MODE_SHADOW: leds[i] = (step_w != (STEP_W+1)'(i));
                    MODE_JOHNSON: begin
                        if (step_w < N_STEPS) begin
                            leds[i] = ((STEP_W+1)'(i) <= step_w);
                        end else begin
                            leds[i] = ((STEP_W+1)'(i) > empty_s);
                        end
                    end
                    default: leds[i] = (step_w == (STEP_W+1)'(i));
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/led_pattern_sequencer.sv =====
// LED pattern sequencer.
// s_ channel: one beat per millisecond tick, s_tdata[0] is the active-low button level.
// m_ channel: one result beat per input beat, carrying the LED drive bits, the
// current mode and a frozen flag.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 step_ticks,
// 1 long_press_ticks) at the clock edge; write only while idle.
// Results are registered, in the skid register while an earlier result waits.
// Throughput: one beat per cycle while s_tready is high, set by the single next-state stage.
// A two-entry output stage (output register plus skid register) lets one more
// beat in while a result waits; s_tready drops only when both are full.
// Reset (aresetn low, synchronous): mode running shadow, step 0, timers and
// press count cleared, pause clear, button taken as released, registers
// back to 200 and 2000 ticks, output stage empty.
`default_nettype none
module led_pattern_sequencer #(
    parameter int LED_COUNT = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lps_pkg::IN_DATA_W-1:0]      s_tdata,  // [0] button_level
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lps_pkg::OUT_DATA_W-1:0]          m_tdata,  // [7:0] leds, [9:8] mode, [10] frozen
    input  wire logic                               cfg_we,
    input  wire lps_pkg::cfg_addr_t                 cfg_addr,
    input  wire logic [lps_pkg::TICK_W-1:0]         cfg_wdata
);
    import lps_pkg::*;

    localparam int STEP_W = $clog2(2 * LED_COUNT);
    localparam logic [STEP_W:0] N_STEPS = (STEP_W+1)'(LED_COUNT);
    localparam logic [STEP_W:0] J_STEPS = (STEP_W+1)'(2 * LED_COUNT);

    logic [TICK_W-1:0] step_ticks_reg;
    logic [TICK_W-1:0] long_press_reg;

    mode_t             mode_reg, mode_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] press_reg, press_next;
    logic              pause_reg, pause_next;
    logic              wait_reg, wait_next;
    logic              last_reg, last_next;

    lps_result_t       out_reg, skid_reg, result;
    logic              m_valid_reg, skid_valid_reg;

    logic              level;
    logic              accept;
    logic [TICK_W-1:0] hold;
    logic [TICK_W:0]   tick_inc;
    logic [STEP_W:0]   step_inc;
    logic [LED_OUT_W-1:0] leds;

    function automatic logic [STEP_W:0] steps_in(input mode_t m);
        return (m == MODE_JOHNSON) ? J_STEPS : N_STEPS;
    endfunction

    assign level    = s_tdata[0];
    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign hold     = (step_ticks_reg == '0) ? TICK_W'(1) : step_ticks_reg;

    always_comb begin
        mode_next  = mode_reg;
        step_next  = step_reg;
        tick_next  = tick_reg;
        press_next = press_reg;
        pause_next = pause_reg;
        wait_next  = wait_reg;
        tick_inc   = {1'b0, tick_reg} + 1'b1;
        step_inc   = {1'b0, step_reg} + 1'b1;
        if (!level) begin
            wait_next = 1'b0;
            if (press_reg != PRESS_MAX) begin
                press_next = press_reg + 1'b1;
            end
        end else if (!last_reg) begin
            if (press_reg >= long_press_reg) begin
                mode_next = (mode_reg >= MODE_LIGHT) ? MODE_SHADOW : mode_reg + 1'b1;
                step_next = '0;
                tick_next = '0;
            end else begin
                pause_next = ~pause_reg;
                if (!pause_reg) begin
                    wait_next = 1'b1;
                end
            end
            press_next = '0;
        end else if (!wait_reg) begin
            if (tick_inc >= {1'b0, hold}) begin
                tick_next = '0;
                if (step_inc >= steps_in(mode_reg)) begin
                    step_next = '0;
                end else begin
                    step_next = step_inc[STEP_W-1:0];
                end
            end else begin
                tick_next = tick_inc[TICK_W-1:0];
            end
        end
        last_next = level;
        if ({1'b0, step_next} >= steps_in(mode_next)) begin
            step_next = '0;
        end
    end

    lps_pattern #(
        .LED_COUNT(LED_COUNT),
        .STEP_W   (STEP_W)
    ) u_pattern (
        .mode(mode_next),
        .step(step_next),
        .leds(leds)
    );

    always_comb begin
        result.leds   = leds;
        result.mode   = mode_next;
        result.frozen = ~level | wait_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg <= STEP_TICKS_RST;
            long_press_reg <= LONG_PRESS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STEP_TICKS: step_ticks_reg <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SHADOW;
            step_reg  <= '0;
            tick_reg  <= '0;
            press_reg <= '0;
            pause_reg <= 1'b0;
            wait_reg  <= 1'b0;
            last_reg  <= 1'b1;
        end else if (accept) begin
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            tick_reg  <= tick_next;
            press_reg <= press_next;
            pause_reg <= pause_next;
            wait_reg  <= wait_next;
            last_reg  <= last_next;
        end
    end

    // output register plus skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!m_valid_reg || m_tready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!m_valid_reg || m_tready) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (m_valid_reg && m_tready && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - RESULT_W)'(0), out_reg};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid beat held with empty output register");

    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_UNUSED)
        else $error("mode register holds unused code");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, step_reg} < steps_in(mode_reg))
        else $error("step position beyond pattern length");

    a_beat_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted beat produced no result");

endmodule
`default_nettype wire

// ===== test/lps_checker.sv =====
module lps_checker (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [0] button_level
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [15:0]             m_tdata,   // [7:0] leds, [9:8] mode, [10] frozen
    input  logic                    cfg_we,
    input  lps_pkg::cfg_addr_t      cfg_addr,
    input  logic [15:0]             cfg_wdata,
    output int                      errors,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lps_pkg::*;

    localparam int N = LED_OUT_W;

    logic [TICK_W-1:0] step_len, long_len;
    mode_t             mode_q;
    logic [4:0]        pos_q;
    logic [TICK_W-1:0] tick_q, press_q;
    logic              paused_q, hold_off_q, prev_level_q;
    lps_result_t       expected_beats[$];

    initial begin
        errors = 0;
        outstanding = 0;
    end

    task automatic report(input string what);
        if (errors < 200) $display("lps_checker: %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic logic [4:0] steps_for(mode_t m);
        return (m == MODE_JOHNSON) ? 5'(2 * N) : 5'(N);
    endfunction

    function automatic logic [N-1:0] leds_for(mode_t m, logic [4:0] s);
        logic [4:0]  k;
        logic [15:0] fill;
        case (m)
            MODE_SHADOW: begin
                return ~(N'(1) << (s % N));
            end
            MODE_JOHNSON: begin
                if (s < N) begin
                    fill = (16'd2 << s) - 16'd1;
                    return fill[N-1:0];
                end
                k = s - 5'(N);
                if (k >= N) k = 5'(N - 1);
                fill = (16'd2 << k) - 16'd1;
                return ~fill[N-1:0];
            end
            default: begin
                return N'(1) << (s % N);
            end
        endcase
    endfunction

    task automatic advance_tick(input logic lvl);
        logic [TICK_W-1:0] hold;
        lps_result_t       r;
        hold = (step_len == '0) ? TICK_W'(1) : step_len;
        if (!lvl) begin
            hold_off_q = 1'b0;
            if (press_q != PRESS_MAX) press_q++;
        end else if (!prev_level_q) begin
            if (press_q >= long_len) begin
                mode_q = (mode_q >= MODE_LIGHT) ? MODE_SHADOW : mode_t'(mode_q + 2'd1);
                pos_q  = '0;
                tick_q = '0;
            end else begin
                paused_q = ~paused_q;
                if (paused_q) hold_off_q = 1'b1;
            end
            press_q = '0;
        end else if (!hold_off_q) begin
            tick_q++;
            if (tick_q >= hold) begin
                tick_q = '0;
                pos_q++;
                if (pos_q >= steps_for(mode_q)) pos_q = '0;
            end
        end
        prev_level_q = lvl;
        if (pos_q >= steps_for(mode_q)) pos_q = '0;
        r.leds   = leds_for(mode_q, pos_q);
        r.mode   = mode_q;
        r.frozen = !lvl || hold_off_q;
        expected_beats.push_back(r);
    endtask

    always @(posedge aclk) begin
        lps_result_t got, want;
        if (!aresetn) begin
            step_len     = STEP_TICKS_RST;
            long_len     = LONG_PRESS_RST;
            mode_q       = MODE_SHADOW;
            pos_q        = '0;
            tick_q       = '0;
            press_q      = '0;
            paused_q     = 1'b0;
            hold_off_q   = 1'b0;
            prev_level_q = 1'b1;
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_STEP_TICKS: step_len = cfg_wdata;
                    REG_LONG_PRESS: long_len = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = lps_result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_beats.size() == 0) begin
                    report($sformatf("result beat %h with nothing expected", m_tdata));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.leds !== want.leds)
                        report($sformatf("leds %h, want %h", got.leds, want.leds));
                    if (got.mode !== want.mode)
                        report($sformatf("mode %0d, want %0d", got.mode, want.mode));
                    if (got.frozen !== want.frozen)
                        report($sformatf("frozen %b, want %b", got.frozen, want.frozen));
                    if ((m_tdata >> RESULT_W) !== '0)
                        report($sformatf("padding bits set in %h", m_tdata));
                end
            end
            if (s_tvalid && s_tready) advance_tick(s_tdata[0]);
        end
        outstanding <= expected_beats.size();
    end

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lps_pkg::*;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;      // [0] button_level
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // [7:0] leds, [9:8] mode, [10] frozen
    logic                  cfg_we   = 1'b0;
    cfg_addr_t             cfg_addr = REG_STEP_TICKS;
    logic [TICK_W-1:0]     cfg_wdata = '0;

    int                    fails;
    int                    outstanding;
    int                    send_idle = 0;
    int                    recv_idle = 0;
    logic [TICK_W-1:0]     long_now  = LONG_PRESS_RST;

    led_pattern_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lps_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .errors      (fails),
        .outstanding (outstanding)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #20_000_000;
        $display("tb: errors");
        $finish;
    end

    // n tick beats at one button level
    task automatic tap(input logic lvl, input int n);
        repeat (n) begin
            while ($urandom_range(0, 99) < send_idle) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_DATA_W-1){1'b0}}, lvl};
            do @(negedge aclk); while (!s_tready);
            @(posedge aclk);
        end
    endtask

    task automatic press(input int n);
        tap(1'b0, n);
        tap(1'b1, 1);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [TICK_W-1:0] st, input logic [TICK_W-1:0] lp);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_STEP_TICKS;
        cfg_wdata <= st;
        @(posedge aclk);
        cfg_addr  <= REG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        long_now   = lp;
    endtask

    // mostly release runs followed by a press, some raw noise
    task automatic run_random(input int n);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) tap(1'($urandom_range(0, 1)), 1);
                sent += len;
            end else begin
                len = (kind == 1) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                tap(1'b1, len);
                sent += len;
                if (long_now > 1 && (long_now > 64 || $urandom_range(0, 1) == 0))
                    len = $urandom_range(1, (long_now > 31) ? 30 : int'(long_now) - 1);
                else
                    len = int'(long_now) + $urandom_range(0, 3);
                if (len < 1) len = 1;
                press(len);
                sent += len + 1;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: short press pauses, next short press resumes
        tap(1'b1, 1);
        press(2);
        tap(1'b1, 2);
        press(1);

        // zero step length and zero long press: every press advances mode
        set_regs(16'd0, 16'd0);
        tap(1'b1, 3);
        press(1);
        tap(1'b1, 3);
        press(1);
        tap(1'b1, 2);
        press(1);

        // long press while paused keeps the pause flag
        set_regs(16'd1, 16'd2);
        press(1);
        press(2);
        tap(1'b1, 2);
        press(1);

        send_idle = 9;
        recv_idle = 63;
        set_regs(16'd1, 16'd1);
        run_random(200);
        set_regs(16'd2, 16'd4);
        run_random(200);
        set_regs(16'd0, 16'd0);
        run_random(100);

        send_idle = 63;
        recv_idle = 9;
        set_regs(16'd3, 16'd6);
        run_random(200);
        set_regs(16'hFFFF, 16'hFFFF);
        run_random(100);
        set_regs(16'd1, 16'd20);
        run_random(150);

        send_idle = 0;
        recv_idle = 0;
        set_regs(TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 40)));
        run_random(150);

        set_regs(STEP_TICKS_RST, LONG_PRESS_RST);
        run_random(100);

        settle();
        if (fails == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
